// ----- rtl/matrix2x2_alu_macros.svh -----
// Assertion macros for the matrix unit port checker
`ifndef MATRIX2X2_ALU_MACROS_SVH
`define MATRIX2X2_ALU_MACROS_SVH

// Same-cycle implication, checked outside reset
`define M2A_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define M2A_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/m2a_pkg.sv -----
// Shared mode codes and pipeline control type for the 2x2 matrix unit
`timescale 1ns / 1ps

package m2a_pkg;

    localparam logic [3:0] MODE_ADD   = 4'd0;
    localparam logic [3:0] MODE_SUB   = 4'd1;
    localparam logic [3:0] MODE_SCALE = 4'd2;
    localparam logic [3:0] MODE_MUL   = 4'd3;
    localparam logic [3:0] MODE_TRANS = 4'd4;
    localparam logic [3:0] MODE_DET   = 4'd5;
    localparam logic [3:0] MODE_TRACE = 4'd6;
    localparam logic [3:0] MODE_DIAG  = 4'd7;
    localparam logic [3:0] MODE_INV   = 4'd8;

    localparam int unsigned THR_WIDTH = 31;

    // Control that travels with each beat
    typedef struct packed {
        logic       valid;
        logic [3:0] mode;
    } m2a_ctl_t;

endpackage

// ----- rtl/m2a_front.sv -----
// Front pipeline: operand capture, products, sums and saturation
`timescale 1ns / 1ps

module m2a_front
    import m2a_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [3:0]          mode,
    input  logic signed [W-1:0] a_in [4],
    input  logic signed [W-1:0] b_in [4],
    input  logic signed [W-1:0] factor,
    output m2a_ctl_t            ctl_out,
    output logic signed [W-1:0] res [4],
    output logic                ovf,
    output logic signed [W-1:0] det,
    output logic                det_ovf,
    output logic signed [W-1:0] a_out [4]
);

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int HW = SW - F;
    localparam int LW = W + 1;

    localparam logic signed [W-1:0]  EMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  EMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [HW-1:0] HMAX = {{(HW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [HW-1:0] HMIN = {{(HW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [LW-1:0] LMAX = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [LW-1:0] LMIN = {2'b11, {(W-1){1'b0}}};

    // Stage 1: capture the beat
    m2a_ctl_t            ctl1_reg;
    logic signed [W-1:0] a1_reg [4];
    logic signed [W-1:0] b1_reg [4];
    logic signed [W-1:0] f1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else
        begin
            ctl1_reg.valid <= in_valid;
            ctl1_reg.mode  <= mode;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= a_in;
        b1_reg <= b_in;
        f1_reg <= factor;
    end

    // Stage 2: select operands, multiply, form the linear results
    logic signed [W-1:0]  x_op [8];
    logic signed [W-1:0]  y_op [8];
    logic signed [LW-1:0] lin_next [4];

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            x_op[k] = '0;
            y_op[k] = '0;
        end
        case (ctl1_reg.mode)
            MODE_MUL:
            begin
                x_op[0] = a1_reg[0]; y_op[0] = b1_reg[0];
                x_op[1] = a1_reg[2]; y_op[1] = b1_reg[1];
                x_op[2] = a1_reg[1]; y_op[2] = b1_reg[0];
                x_op[3] = a1_reg[3]; y_op[3] = b1_reg[1];
                x_op[4] = a1_reg[0]; y_op[4] = b1_reg[2];
                x_op[5] = a1_reg[2]; y_op[5] = b1_reg[3];
                x_op[6] = a1_reg[1]; y_op[6] = b1_reg[2];
                x_op[7] = a1_reg[3]; y_op[7] = b1_reg[3];
            end
            MODE_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    x_op[2*i] = a1_reg[i];
                    y_op[2*i] = f1_reg;
                end
            end
            MODE_DET, MODE_INV:
            begin
                x_op[0] = a1_reg[0]; y_op[0] = a1_reg[3];
                x_op[1] = a1_reg[1]; y_op[1] = a1_reg[2];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lin_next[i] = '0;
        end
        case (ctl1_reg.mode)
            MODE_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lin_next[i] = LW'(a1_reg[i]) + LW'(b1_reg[i]);
                end
            end
            MODE_SUB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lin_next[i] = LW'(a1_reg[i]) - LW'(b1_reg[i]);
                end
            end
            MODE_TRANS:
            begin
                lin_next[0] = LW'(a1_reg[0]);
                lin_next[1] = LW'(a1_reg[2]);
                lin_next[2] = LW'(a1_reg[1]);
                lin_next[3] = LW'(a1_reg[3]);
            end
            MODE_TRACE:
            begin
                lin_next[0] = LW'(a1_reg[0]) + LW'(a1_reg[3]);
            end
            MODE_DIAG:
            begin
                lin_next[0] = LW'(a1_reg[0]);
                lin_next[1] = LW'(a1_reg[3]);
            end
            default:
            begin
            end
        endcase
    end

    m2a_ctl_t             ctl2_reg;
    logic signed [PW-1:0] p2_reg [8];
    logic signed [LW-1:0] lin2_reg [4];
    logic signed [W-1:0]  a2_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 8; k++)
        begin
            p2_reg[k] <= PW'(x_op[k]) * PW'(y_op[k]);
        end
        lin2_reg <= lin_next;
        a2_reg   <= a1_reg;
    end

    // Stage 3: add product pairs (subtract them for DET and INV) and shift out the fraction
    logic signed [SW-1:0] sum_next [4];
    logic                 det_sub;

    assign det_sub = (ctl2_reg.mode == MODE_DET) || (ctl2_reg.mode == MODE_INV);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (det_sub)
            begin
                sum_next[k] = SW'(p2_reg[2*k]) - SW'(p2_reg[2*k+1]);
            end
            else
            begin
                sum_next[k] = SW'(p2_reg[2*k]) + SW'(p2_reg[2*k+1]);
            end
        end
    end

    m2a_ctl_t             ctl3_reg;
    logic signed [HW-1:0] s3_reg [4];
    logic signed [LW-1:0] lin3_reg [4];
    logic signed [W-1:0]  a3_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
        end
        else
        begin
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            s3_reg[k] <= sum_next[k][SW-1:F];
        end
        lin3_reg <= lin2_reg;
        a3_reg   <= a2_reg;
    end

    // Stage 4: saturate and pick the result kind
    logic signed [W-1:0] sat_s [4];
    logic signed [W-1:0] sat_l [4];
    logic [3:0]          ov_s;
    logic [3:0]          ov_l;
    logic                prod_mode;

    assign prod_mode = (ctl3_reg.mode == MODE_SCALE) || (ctl3_reg.mode == MODE_MUL) ||
                       (ctl3_reg.mode == MODE_DET);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ov_s[k]  = (s3_reg[k] > HMAX) || (s3_reg[k] < HMIN);
            sat_s[k] = (s3_reg[k] > HMAX) ? EMAX :
                       (s3_reg[k] < HMIN) ? EMIN : s3_reg[k][W-1:0];
            ov_l[k]  = (lin3_reg[k] > LMAX) || (lin3_reg[k] < LMIN);
            sat_l[k] = (lin3_reg[k] > LMAX) ? EMAX :
                       (lin3_reg[k] < LMIN) ? EMIN : lin3_reg[k][W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_out <= '0;
        end
        else
        begin
            ctl_out <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            res[k] <= prod_mode ? sat_s[k] : sat_l[k];
        end
        ovf     <= prod_mode ? (|ov_s) : (|ov_l);
        det     <= sat_s[0];
        det_ovf <= ov_s[0];
        a_out   <= a3_reg;
    end

endmodule

// ----- rtl/m2a_div.sv -----
// One lane of the pipelined unsigned restoring divider, one quotient bit a stage
`timescale 1ns / 1ps

module m2a_div #(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  logic             clk,
    input  logic [W+F-1:0]   num,
    input  logic [W-1:0]     den,
    output logic [W+F-1:0]   quo
);

    localparam int N = W + F;

    logic [W-1:0] rem_reg [N];
    logic [N-1:0] nq_reg [N];
    logic [W-1:0] den_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [W-1:0] rin;
        logic [N-1:0] qin;
        logic [W-1:0] din;
        logic [W:0]   trial;
        logic         ge;

        if (k == 0)
        begin : g_first
            assign rin = '0;
            assign qin = num;
            assign din = den;
        end
        else
        begin : g_next
            assign rin = rem_reg[k-1];
            assign qin = nq_reg[k-1];
            assign din = den_reg[k-1];
        end

        // Shift in the next numerator bit and try the subtract
        assign trial = {rin, qin[N-1]};
        assign ge    = trial >= {1'b0, din};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? W'(trial - {1'b0, din}) : trial[W-1:0];
            nq_reg[k]  <= {qin[N-2:0], ge};
            den_reg[k] <= din;
        end
    end

    assign quo = nq_reg[N-1];

endmodule

// ----- rtl/matrix2x2_alu.sv -----
// Top level of the pipelined 2x2 fixed-point matrix unit
//
//  Channel   Handshake          Payload
//  command   start / busy       mode, a11 a21 a12 a22, b11 b21 b12 b22, factor
//  result    done (one cycle)   r11 r21 r12 r22, singular, overflow
//  config    cfg_we             cfg_data (singular threshold)
//
// A beat is taken on every cycle with start high; busy is never raised.
// Each result passes the front stages, stage 5, the divider with its matched
// delay line and the output register; the divider yields one quotient bit per stage.
// Results leave in command order, one per cycle at most, for one cycle only.
// Reset clears all valid bits and sets the threshold to 1.
`timescale 1ns / 1ps

module matrix2x2_alu
    import m2a_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   mode,
    input  logic signed [ELEM_WIDTH-1:0] a11,
    input  logic signed [ELEM_WIDTH-1:0] a21,
    input  logic signed [ELEM_WIDTH-1:0] a12,
    input  logic signed [ELEM_WIDTH-1:0] a22,
    input  logic signed [ELEM_WIDTH-1:0] b11,
    input  logic signed [ELEM_WIDTH-1:0] b21,
    input  logic signed [ELEM_WIDTH-1:0] b12,
    input  logic signed [ELEM_WIDTH-1:0] b22,
    input  logic signed [ELEM_WIDTH-1:0] factor,
    input  logic                         cfg_we,
    input  logic [THR_WIDTH-1:0]         cfg_data,
    output logic                         done,
    output logic signed [ELEM_WIDTH-1:0] r11,
    output logic signed [ELEM_WIDTH-1:0] r21,
    output logic signed [ELEM_WIDTH-1:0] r12,
    output logic signed [ELEM_WIDTH-1:0] r22,
    output logic                         singular,
    output logic                         overflow
);

    localparam int W  = ELEM_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int N  = W + F;
    localparam int CW = (W > THR_WIDTH) ? W : THR_WIDTH;

    localparam logic signed [W-1:0] EMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] EMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [N-1:0]        QPOS   = N'({1'b0, {(W-1){1'b1}}});
    localparam logic [N-1:0]        QNEG   = N'({1'b1, {(W-1){1'b0}}});

    assign busy = 1'b0;

    // Threshold register
    logic [THR_WIDTH-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Front stages
    logic signed [W-1:0] a_in [4];
    logic signed [W-1:0] b_in [4];
    m2a_ctl_t            ctl4;
    logic signed [W-1:0] res4 [4];
    logic                ovf4;
    logic signed [W-1:0] det4;
    logic                det_ovf4;
    logic signed [W-1:0] a4 [4];

    assign a_in[0] = a11;
    assign a_in[1] = a21;
    assign a_in[2] = a12;
    assign a_in[3] = a22;
    assign b_in[0] = b11;
    assign b_in[1] = b21;
    assign b_in[2] = b12;
    assign b_in[3] = b22;

    m2a_front #(
        .W (W),
        .F (F)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .mode     (mode),
        .a_in     (a_in),
        .b_in     (b_in),
        .factor   (factor),
        .ctl_out  (ctl4),
        .res      (res4),
        .ovf      (ovf4),
        .det      (det4),
        .det_ovf  (det_ovf4),
        .a_out    (a4)
    );

    // Stage 5: singular test, divider operands, bypass result
    logic                dneg;
    logic [W-1:0]        dmag;
    logic                is_sing;
    logic                is_inv;
    logic signed [W-1:0] adj_src [4];
    logic [3:0]          adj_neg;
    logic [N-1:0]        num_next [4];
    logic [3:0]          qneg_next;
    logic signed [W-1:0] byp_next [4];
    logic                bov_next;

    assign dneg    = det4[W-1];
    assign dmag    = dneg ? W'(-det4) : det4;
    assign is_sing = (det4 == '0) || (CW'(dmag) < CW'(thr_reg));
    assign is_inv  = (ctl4.mode == MODE_INV);

    assign adj_src[0] = a4[3];
    assign adj_src[1] = a4[1];
    assign adj_src[2] = a4[2];
    assign adj_src[3] = a4[0];
    assign adj_neg[0] = a4[3][W-1];
    assign adj_neg[1] = !a4[1][W-1] && (a4[1] != '0);
    assign adj_neg[2] = !a4[2][W-1] && (a4[2] != '0);
    assign adj_neg[3] = a4[0][W-1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            num_next[i]  = {(adj_src[i][W-1] ? W'(-adj_src[i]) : adj_src[i]),
                            {F{1'b0}}};
            qneg_next[i] = adj_neg[i] ^ dneg;
            if (is_inv)
            begin
                byp_next[i] = is_sing ? a4[i] : '0;
            end
            else
            begin
                byp_next[i] = res4[i];
            end
        end
        if (is_inv)
        begin
            bov_next = is_sing ? 1'b0 : det_ovf4;
        end
        else
        begin
            bov_next = ovf4;
        end
    end

    logic                v5_reg;
    logic [N-1:0]        num5_reg [4];
    logic [W-1:0]        den5_reg;
    logic signed [W-1:0] byp5_reg [4];
    logic                bov5_reg;
    logic                sing5_reg;
    logic                div5_reg;
    logic [3:0]          qneg5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= ctl4.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num5_reg  <= num_next;
        den5_reg  <= dmag;
        byp5_reg  <= byp_next;
        bov5_reg  <= bov_next;
        sing5_reg <= is_inv && is_sing;
        div5_reg  <= is_inv && !is_sing;
        qneg5_reg <= qneg_next;
    end

    // Divider lanes, one per adjugate element
    logic [N-1:0] quo [4];

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        m2a_div #(
            .W (W),
            .F (F)
        ) u_div (
            .clk (clk),
            .num (num5_reg[i]),
            .den (den5_reg),
            .quo (quo[i])
        );
    end

    // Side band delay line, matched to the divider depth
    logic                dl_v_reg [N];
    logic signed [W-1:0] dl_byp_reg [N][4];
    logic                dl_bov_reg [N];
    logic                dl_sing_reg [N];
    logic                dl_div_reg [N];
    logic [3:0]          dl_qneg_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                dl_v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            dl_v_reg[0] <= v5_reg;
            for (int k = 1; k < N; k++)
            begin
                dl_v_reg[k] <= dl_v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dl_byp_reg[0]  <= byp5_reg;
        dl_bov_reg[0]  <= bov5_reg;
        dl_sing_reg[0] <= sing5_reg;
        dl_div_reg[0]  <= div5_reg;
        dl_qneg_reg[0] <= qneg5_reg;
        for (int k = 1; k < N; k++)
        begin
            dl_byp_reg[k]  <= dl_byp_reg[k-1];
            dl_bov_reg[k]  <= dl_bov_reg[k-1];
            dl_sing_reg[k] <= dl_sing_reg[k-1];
            dl_div_reg[k]  <= dl_div_reg[k-1];
            dl_qneg_reg[k] <= dl_qneg_reg[k-1];
        end
    end

    // Final stage: sign and saturate the quotients, merge with the bypass
    logic signed [W-1:0] fin_next [4];
    logic [3:0]          qov;
    logic signed [W-1:0] qval [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (dl_qneg_reg[N-1][i])
            begin
                qov[i]  = quo[i] > QNEG;
                qval[i] = (quo[i] > QNEG) ? EMIN : W'(-quo[i][W-1:0]);
            end
            else
            begin
                qov[i]  = quo[i] > QPOS;
                qval[i] = (quo[i] > QPOS) ? EMAX : quo[i][W-1:0];
            end
            fin_next[i] = dl_div_reg[N-1] ? qval[i] : dl_byp_reg[N-1][i];
        end
    end

    logic                done_reg;
    logic signed [W-1:0] r_reg [4];
    logic                sing_reg;
    logic                ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dl_v_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= fin_next;
        sing_reg <= dl_sing_reg[N-1];
        ov_reg   <= dl_bov_reg[N-1] || (dl_div_reg[N-1] && (|qov));
    end

    assign done     = done_reg;
    assign r11      = r_reg[0];
    assign r21      = r_reg[1];
    assign r12      = r_reg[2];
    assign r22      = r_reg[3];
    assign singular = sing_reg;
    assign overflow = ov_reg;

endmodule

// ----- rtl/m2a_chk.sv -----
// Port-level checker for the matrix unit, bound to the top level
`timescale 1ns / 1ps
`include "matrix2x2_alu_macros.svh"

module m2a_chk #(
    parameter int LAT = 54
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic singular,
    input logic overflow
);

    `M2A_ASSERT_NOW(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")
    `M2A_ASSERT_NOW(a_sing_no_ovf, clk, rst_n, done && singular, !overflow, "singular with overflow")
    `M2A_ASSERT_NOW(a_done_has_cmd, clk, rst_n, done, $past(start, LAT), "result without command")
    `M2A_ASSERT_NOW(a_cmd_gives_done, clk, rst_n, start, ##LAT done, "command lost")

endmodule

bind matrix2x2_alu m2a_chk #(
    .LAT (ELEM_WIDTH + FRAC_BITS + 6)
) u_m2a_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .singular (singular),
    .overflow (overflow)
);

// ----- tb/sv/matrix2x2_alu_checker.sv -----
// Result checker for the 2x2 matrix unit: predicts each result and compares
`timescale 1ns / 1ps

module matrix2x2_alu_checker
    import m2a_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [3:0]          mode,
    input  logic signed [31:0]  a11,
    input  logic signed [31:0]  a21,
    input  logic signed [31:0]  a12,
    input  logic signed [31:0]  a22,
    input  logic signed [31:0]  b11,
    input  logic signed [31:0]  b21,
    input  logic signed [31:0]  b12,
    input  logic signed [31:0]  b22,
    input  logic signed [31:0]  factor,
    input  logic                cfg_we,
    input  logic [THR_WIDTH-1:0] cfg_data,
    input  logic                done,
    input  logic signed [31:0]  r11,
    input  logic signed [31:0]  r21,
    input  logic signed [31:0]  r12,
    input  logic signed [31:0]  r22,
    input  logic                singular,
    input  logic                overflow,
    output int                  fail_count,
    output int                  pending
);

    typedef struct {
        logic signed [31:0] e [4];
        logic               sing;
        logic               ovf;
    } matrix_result_t;

    localparam longint ELEM_MAX = 64'sd2147483647;
    localparam longint ELEM_MIN = -64'sd2147483648;

    matrix_result_t expected_q [$];
    logic [THR_WIDTH-1:0] threshold;

    // Clamp to the element range, noting any saturation
    function automatic longint clamp(input longint x, inout logic ovf);
        if (x > ELEM_MAX) begin
            ovf = 1'b1;
            return ELEM_MAX;
        end
        if (x < ELEM_MIN) begin
            ovf = 1'b1;
            return ELEM_MIN;
        end
        return x;
    endfunction

    // Exact floor((p + q) / 2^16); the sum of two products fits 64 bits
    // only through 65-bit arithmetic, so widen first
    function automatic longint floor_shift(input longint p, input longint q);
        logic signed [64:0] s;
        s = 65'(signed'(p)) + 65'(signed'(q));
        s = s >>> 16;
        return longint'(s);
    endfunction

    function automatic matrix_result_t compute_matrix(
        input logic [3:0] m, input longint a [4], input longint b [4],
        input longint f, input logic [THR_WIDTH-1:0] thr);
        matrix_result_t res;
        longint r [4];
        longint d, ad;
        logic ovf;
        ovf = 1'b0;
        res.sing = 1'b0;
        r = '{0, 0, 0, 0};
        case (m)
            MODE_ADD:
                for (int i = 0; i < 4; i++) r[i] = clamp(a[i] + b[i], ovf);
            MODE_SUB:
                for (int i = 0; i < 4; i++) r[i] = clamp(a[i] - b[i], ovf);
            MODE_SCALE:
                for (int i = 0; i < 4; i++) r[i] = clamp((a[i] * f) >>> 16, ovf);
            MODE_MUL:
            begin
                r[0] = clamp(floor_shift(a[0] * b[0], a[2] * b[1]), ovf);
                r[1] = clamp(floor_shift(a[1] * b[0], a[3] * b[1]), ovf);
                r[2] = clamp(floor_shift(a[0] * b[2], a[2] * b[3]), ovf);
                r[3] = clamp(floor_shift(a[1] * b[2], a[3] * b[3]), ovf);
            end
            MODE_TRANS:
            begin
                r[0] = a[0]; r[1] = a[2]; r[2] = a[1]; r[3] = a[3];
            end
            MODE_DET:
                r[0] = clamp(floor_shift(a[0] * a[3], -(a[1] * a[2])), ovf);
            MODE_TRACE:
                r[0] = clamp(a[0] + a[3], ovf);
            MODE_DIAG:
            begin
                r[0] = a[0]; r[1] = a[3];
            end
            MODE_INV:
            begin
                d = clamp(floor_shift(a[0] * a[3], -(a[1] * a[2])), ovf);
                ad = (d < 0) ? -d : d;
                if (d == 0 || ad < longint'(thr)) begin
                    res.sing = 1'b1;
                    ovf = 1'b0;
                    r = a;
                end
                else begin
                    // SV division truncates toward zero
                    r[0] = clamp((a[3] * 65536) / d, ovf);
                    r[1] = clamp((-a[1] * 65536) / d, ovf);
                    r[2] = clamp((-a[2] * 65536) / d, ovf);
                    r[3] = clamp((a[0] * 65536) / d, ovf);
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++) res.e[i] = r[i][31:0];
        res.ovf = ovf;
        return res;
    endfunction

    // Predict on each accepted beat, compare on each result beat
    always @(posedge clk or negedge rst_n)
    begin
        longint a [4];
        longint b [4];
        logic signed [31:0] got [4];
        matrix_result_t want;
        int errs;
        if (!rst_n) begin
            threshold <= 1;
            fail_count <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else begin
            errs = 0;
            if (cfg_we) threshold <= cfg_data;
            if (start && !busy) begin
                a = '{a11, a21, a12, a22};
                b = '{b11, b21, b12, b22};
                expected_q.push_back(compute_matrix(mode, a, b, factor, threshold));
            end
            if (done) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end
                else begin
                    want = expected_q.pop_front();
                    got = '{r11, r21, r12, r22};
                    for (int i = 0; i < 4; i++)
                        if (got[i] !== want.e[i]) begin
                            $error("r%0d: expected %0d got %0d",
                                   (i % 2 + 1) * 10 + i / 2 + 1, want.e[i], got[i]);
                            errs++;
                        end
                    if (singular !== want.sing) begin
                        $error("singular: expected %0b got %0b", want.sing, singular);
                        errs++;
                    end
                    if (overflow !== want.ovf) begin
                        $error("overflow: expected %0b got %0b", want.ovf, overflow);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= expected_q.size();
        end
    end

endmodule

// ----- tb/sv/matrix2x2_alu_tb.sv -----
// Testbench top for the 2x2 matrix unit: stimulus, config phases and verdict
`timescale 1ns / 1ps

module matrix2x2_alu_tb;
    import m2a_pkg::*;

    localparam int LATENCY = 54;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [3:0] mode = MODE_ADD;
    logic signed [31:0] a11 = '0, a21 = '0, a12 = '0, a22 = '0;
    logic signed [31:0] b11 = '0, b21 = '0, b12 = '0, b22 = '0;
    logic signed [31:0] factor = '0;
    logic cfg_we = 1'b0;
    logic [THR_WIDTH-1:0] cfg_data = '0;
    logic done, singular, overflow;
    logic signed [31:0] r11, r21, r12, r22;
    int fail_count, pending;
    int cycles = 0;

    always #1 clk = ~clk;

    matrix2x2_alu i_dut (.*);

    matrix2x2_alu_checker i_checker (.*);

    // Give up at the cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_elem();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh00010000;
            3: return 32'shFFFF0000;
            4: return '0;
            5, 6: return $urandom;
            default: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
        endcase
    endfunction

    // Drive one command beat; busy is checked after each rising edge
    task automatic send_beat(input logic [3:0] m, input logic signed [31:0] v [9]);
        mode <= m;
        {a11, a21, a12, a22} <= {v[0], v[1], v[2], v[3]};
        {b11, b21, b12, b22} <= {v[4], v[5], v[6], v[7]};
        factor <= v[8];
        start <= 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic random_beat();
        logic signed [31:0] v [9];
        logic [3:0] m;
        for (int i = 0; i < 9; i++) v[i] = pick_elem();
        m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
        // Make some inverses hit a zero determinant
        if (m == MODE_INV && $urandom_range(0, 5) == 0) begin
            v[2] = v[0];
            v[3] = v[1];
        end
        send_beat(m, v);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic in bursts, with gaps between some of them
    task automatic random_phase(input int count);
        int left;
        left = count;
        while (left > 0) begin
            for (int n = $urandom_range(1, 20); n > 0 && left > 0; n--) begin
                random_beat();
                left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        logic signed [31:0] v [9];
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every mode at the field extremes, reset threshold
        for (int m = 0; m < 10; m++) begin
            v = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                  32'sh80000000};
            send_beat(4'(m), v);
        end
        for (int m = 0; m < 9; m++) begin
            v = '{32'sh00020000, 32'sh00010000, 32'shFFFF0000, 32'sh00030000,
                  32'sh00008000, 32'shFFFFFFFF, 32'sh00000001, 32'shFFFFFFFF,
                  32'shFFFF8000};
            send_beat(4'(m), v);
        end
        // Zero determinant, tiny determinant, and the top mode code
        v = '{32'sh00010000, 32'sh00020000, 32'sh00010000, 32'sh00020000,
              0, 0, 0, 0, 0};
        send_beat(MODE_INV, v);
        v = '{32'sh00000100, 0, 0, 32'sh00000100, 0, 0, 0, 0, 0};
        send_beat(MODE_INV, v);
        v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_beat(4'hF, v);
        drain();

        // Zero threshold: only an exact zero determinant is singular
        write_threshold('0);
        v = '{32'sh00010000, 32'sh00010000, 32'sh00010000, 32'sh00010000,
              0, 0, 0, 0, 0};
        send_beat(MODE_INV, v);
        v = '{1, 0, 0, 32'sh00010000, 0, 0, 0, 0, 0};
        send_beat(MODE_INV, v);
        random_phase(150);
        drain();

        write_threshold('1);
        random_phase(150);
        drain();

        write_threshold(31'h0000_8000);
        random_phase(150);
        drain();

        write_threshold(31'($urandom));
        random_phase(170);
        drain();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
